>>> hdl/sld_pkg.sv
// ----------------------------------------------------------------------------
// sld_pkg
// Shared types and constants for the sync/length/XOR frame receiver.
// ----------------------------------------------------------------------------
`default_nettype none

package sld_pkg;

  localparam logic [31:0] SYNC_WORD_RESET = 32'h53594E43;

  localparam int unsigned CFG_ADDR_W = 3;
  localparam logic [0:0]  REG_SYNC_WORD = 1'b0;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       is_end;
    logic       frame_ok;
    logic [7:0] frame_length;
  } res_t;

  typedef struct packed {
    logic valid;
    res_t word;
  } head_t;

endpackage

`default_nettype wire

>>> hdl/sld_if.sv
// ----------------------------------------------------------------------------
// sld_in_if / sld_out_if
// Valid/ready channels for received bytes and for result words.
// ----------------------------------------------------------------------------
`default_nettype none

interface sld_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface sld_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       is_end;
  logic       frame_ok;
  logic [7:0] frame_length;

  modport source (output valid, output data_byte, output is_end, output frame_ok,
                  output frame_length, input ready);
  modport sink (input valid, input data_byte, input is_end, input frame_ok,
                input frame_length, output ready);
endinterface

`default_nettype wire

>>> hdl/sync_length_xor_deframer.sv
// ----------------------------------------------------------------------------
// sync_length_xor_deframer
// Sync-word hunt, length-prefixed frame receiver with XOR checksum check.
//
//   channel   dir  handshake              payload
//   in_chan   in   valid/ready            rx_byte
//   out_chan  out  valid/ready            data_byte, is_end, frame_ok,
//                                         frame_length
//   cfg_*     in   APB write/read         sync_word at byte address 0
//
// One byte per cycle is taken while the result queue has room; the phase state
// machine in the classifier handles each byte in the cycle it is accepted.
// Each result word passes through the result queue and the output register.
// The result queue absorbs output stalls; in_chan.ready drops only when
// the queue is full.
// rst_n is synchronous; sync_word returns to "SYNC" and the hunt restarts.
// ----------------------------------------------------------------------------
`default_nettype none

module sync_length_xor_deframer #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  sld_in_if.sink                                  in_chan,
  sld_out_if.source                               out_chan,
  input  wire logic                               cfg_psel,
  input  wire logic                               cfg_penable,
  input  wire logic                               cfg_pwrite,
  input  wire logic [sld_pkg::CFG_ADDR_W-1:0]     cfg_paddr,
  input  wire logic [31:0]                        cfg_pwdata,
  output logic [31:0]                             cfg_prdata,
  output logic                                    cfg_pready
);

  logic [31:0]     sync_word_r;
  logic            q_ready;
  logic            push;
  logic            pop;
  logic            in_ready;
  sld_pkg::res_t   push_word;
  sld_pkg::res_t   out_word;
  sld_pkg::head_t  head;
  logic            sel_sync;

  assign sel_sync   = (cfg_paddr[sld_pkg::CFG_ADDR_W-1] == sld_pkg::REG_SYNC_WORD);
  assign cfg_pready = 1'b1;
  assign cfg_prdata = sel_sync ? sync_word_r : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_word_r <= sld_pkg::SYNC_WORD_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && sel_sync) begin
      sync_word_r <= cfg_pwdata;
    end
  end

  sld_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .sync_word (sync_word_r),
    .in_valid  (in_chan.valid),
    .in_byte   (in_chan.rx_byte),
    .q_ready   (q_ready),
    .in_ready  (in_ready),
    .push      (push),
    .push_word (push_word)
  );

  assign in_chan.ready = in_ready;

  sld_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_word (push_word),
    .q_ready   (q_ready),
    .pop       (pop),
    .head      (head)
  );

  sld_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .pop       (pop),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .out_word  (out_word)
  );

  assign out_chan.data_byte    = out_word.data_byte;
  assign out_chan.is_end       = out_word.is_end;
  assign out_chan.frame_ok     = out_word.frame_ok;
  assign out_chan.frame_length = out_word.frame_length;

endmodule

`default_nettype wire

>>> hdl/sld_front.sv
// ----------------------------------------------------------------------------
// sld_front
// Byte classifier: sync hunt, length, payload and checksum phases.
// Emits one result word per payload byte and one per checksum byte.
// ----------------------------------------------------------------------------
`default_nettype none

module sld_front (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic [31:0]      sync_word,
  input  wire logic             in_valid,
  input  wire logic [7:0]       in_byte,
  input  wire logic             q_ready,
  output logic                  in_ready,
  output logic                  push,
  output sld_pkg::res_t         push_word
);

  localparam logic [1:0] PH_HUNT = 2'd0;
  localparam logic [1:0] PH_LEN  = 2'd1;
  localparam logic [1:0] PH_DATA = 2'd2;
  localparam logic [1:0] PH_SUM  = 2'd3;

  logic [1:0] phase_r, phase_nxt;
  logic [1:0] matched_r, matched_nxt;
  logic [7:0] left_r, left_nxt;
  logic [7:0] xor_r, xor_nxt;
  logic [7:0] len_r, len_nxt;
  logic [7:0] expect_byte;
  logic       accept;

  assign in_ready = q_ready;
  assign accept   = in_valid && q_ready;

  always_comb begin
    unique case (matched_r)
      2'd0:    expect_byte = sync_word[31:24];
      2'd1:    expect_byte = sync_word[23:16];
      2'd2:    expect_byte = sync_word[15:8];
      default: expect_byte = sync_word[7:0];
    endcase
  end

  always_comb begin
    phase_nxt   = phase_r;
    matched_nxt = matched_r;
    left_nxt    = left_r;
    xor_nxt     = xor_r;
    len_nxt     = len_r;
    push        = 1'b0;
    push_word   = '0;
    if (accept) begin
      unique case (phase_r)
        PH_HUNT: begin
          if (in_byte == expect_byte) begin
            if (matched_r == 2'd3) begin
              matched_nxt = 2'd0;
              phase_nxt   = PH_LEN;
            end else begin
              matched_nxt = matched_r + 2'd1;
            end
          end else begin
            matched_nxt = (in_byte == sync_word[31:24]) ? 2'd1 : 2'd0;
          end
        end
        PH_LEN: begin
          len_nxt   = in_byte;
          left_nxt  = in_byte;
          xor_nxt   = 8'd0;
          phase_nxt = (in_byte == 8'd0) ? PH_SUM : PH_DATA;
        end
        PH_DATA: begin
          xor_nxt   = xor_r ^ in_byte;
          left_nxt  = left_r - 8'd1;
          if (left_r == 8'd1) begin
            phase_nxt = PH_SUM;
          end
          push                = 1'b1;
          push_word.data_byte = in_byte;
        end
        default: begin
          push                   = 1'b1;
          push_word.is_end       = 1'b1;
          push_word.frame_ok     = (xor_r == in_byte);
          push_word.frame_length = len_r;
          phase_nxt              = PH_HUNT;
          matched_nxt            = 2'd0;
          left_nxt               = 8'd0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_HUNT;
      matched_r <= 2'd0;
      left_r    <= 8'd0;
      xor_r     <= 8'd0;
      len_r     <= 8'd0;
    end else begin
      phase_r   <= phase_nxt;
      matched_r <= matched_nxt;
      left_r    <= left_nxt;
      xor_r     <= xor_nxt;
      len_r     <= len_nxt;
    end
  end

endmodule

`default_nettype wire

>>> hdl/sld_queue.sv
// ----------------------------------------------------------------------------
// sld_queue
// Short FIFO of result words between the classifier and the output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module sld_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire sld_pkg::res_t push_word,
  output logic               q_ready,
  input  wire logic          pop,
  output sld_pkg::head_t     head
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL = CNT_W'(DEPTH);

  sld_pkg::res_t    mem_r [DEPTH];
  logic [PTR_W-1:0] wr_r, rd_r;
  logic [CNT_W-1:0] cnt_r;
  logic             do_push, do_pop;

  assign q_ready    = (cnt_r != FULL);
  assign do_push    = push && q_ready;
  assign do_pop     = pop && (cnt_r != '0);
  assign head.valid = (cnt_r != '0);
  assign head.word  = mem_r[rd_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_r] <= push_word;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) begin
        wr_r <= (wr_r == LAST) ? '0 : wr_r + PTR_W'(1);
      end
      if (do_pop) begin
        rd_r <= (rd_r == LAST) ? '0 : rd_r + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - CNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

>>> hdl/sld_back.sv
// ----------------------------------------------------------------------------
// sld_back
// Output stage: takes words from the queue into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module sld_back (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire sld_pkg::head_t head,
  output logic                pop,
  output logic                out_valid,
  input  wire logic           out_ready,
  output sld_pkg::res_t       out_word
);

  logic          valid_r;
  sld_pkg::res_t word_r;

  assign pop       = head.valid && (!valid_r || out_ready);
  assign out_valid = valid_r;
  assign out_word  = word_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (pop) begin
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      word_r <= head.word;
    end
  end

endmodule

`default_nettype wire

>>> hdl/sld_checker.sv
// ----------------------------------------------------------------------------
// sld_checker
// Port-level checks on the result channel of the frame receiver.
// ----------------------------------------------------------------------------
`default_nettype none

module sld_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] data_byte,
  input wire logic       is_end,
  input wire logic       frame_ok,
  input wire logic [7:0] frame_length
);

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(data_byte) && $stable(is_end)
      && $stable(frame_ok) && $stable(frame_length))
    else $error("stalled result word changed");

  a_end_zero_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && is_end |-> data_byte == 8'd0)
    else $error("end record carries payload byte");

  a_data_zero_meta: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !is_end |-> !frame_ok && frame_length == 8'd0)
    else $error("payload word carries end fields");

endmodule

bind sync_length_xor_deframer sld_checker u_sld_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_chan.valid),
  .out_ready    (out_chan.ready),
  .data_byte    (out_chan.data_byte),
  .is_end       (out_chan.is_end),
  .frame_ok     (out_chan.frame_ok),
  .frame_length (out_chan.frame_length)
);

`default_nettype wire

>>> tb/sld_frame_checker.sv
// ----------------------------------------------------------------------------
// sld_frame_checker
// Watches the byte, result and register channels of the deframer, keeps its
// own copy of the sync hunt and frame state, and compares every result word
// in order against the words that the accepted bytes call for. Register
// readbacks are checked against the tracked sync word.
// ----------------------------------------------------------------------------
module sld_frame_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  sld_in_if                              in_mon,
  sld_out_if                             out_mon,
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic [sld_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [31:0]                    cfg_pwdata,
  input  logic [31:0]                    cfg_prdata,
  input  logic                           cfg_pready,
  output int unsigned                    fail_count,
  output int unsigned                    pending
);
  import sld_pkg::*;

  localparam int unsigned PRINT_CAP = 40;

  typedef enum logic [1:0] {
    HUNT_SYNC,
    TAKE_LENGTH,
    TAKE_PAYLOAD,
    TAKE_CHECKSUM
  } rx_phase_e;

  logic [31:0] sync_word;
  rx_phase_e   rx_phase;
  logic [2:0]  sync_hits;
  logic [7:0]  bytes_left;
  logic [7:0]  running_xor;
  logic [7:0]  frame_len;
  res_t        frame_words[$];

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  task automatic report_mismatch(input string what, input logic [31:0] seen,
                                 input logic [31:0] want);
    if (fail_count < PRINT_CAP) begin
      $display("deframer mismatch: %s seen %0h expected %0h", what, seen, want);
    end
    fail_count++;
  endtask

  function automatic logic [7:0] sync_byte_at(input logic [2:0] pos);
    return sync_word[31 - 8 * pos[1:0] -: 8];
  endfunction

  // Advance the frame state by one byte; return 1 when a word is due.
  function automatic bit deframe_byte(input logic [7:0] b, output res_t word);
    word = '0;
    case (rx_phase)
      HUNT_SYNC: begin
        if (b == sync_byte_at(sync_hits)) begin
          if (sync_hits == 3'd3) begin
            sync_hits = 3'd0;
            rx_phase  = TAKE_LENGTH;
          end else begin
            sync_hits = sync_hits + 3'd1;
          end
        end else begin
          sync_hits = (b == sync_byte_at(3'd0)) ? 3'd1 : 3'd0;
        end
        return 1'b0;
      end
      TAKE_LENGTH: begin
        frame_len   = b;
        bytes_left  = b;
        running_xor = 8'h00;
        rx_phase    = (b == 8'h00) ? TAKE_CHECKSUM : TAKE_PAYLOAD;
        return 1'b0;
      end
      TAKE_PAYLOAD: begin
        running_xor = running_xor ^ b;
        bytes_left  = bytes_left - 8'd1;
        if (bytes_left == 8'h00) rx_phase = TAKE_CHECKSUM;
        word.data_byte = b;
        return 1'b1;
      end
      default: begin
        word.is_end       = 1'b1;
        word.frame_ok     = (running_xor == b);
        word.frame_length = frame_len;
        rx_phase   = HUNT_SYNC;
        sync_hits  = 3'd0;
        bytes_left = 8'h00;
        return 1'b1;
      end
    endcase
  endfunction

  always @(posedge clk) begin : track
    res_t predicted;
    res_t seen;
    res_t want;
    if (!rst_n) begin
      sync_word   = SYNC_WORD_RESET;
      rx_phase    = HUNT_SYNC;
      sync_hits   = 3'd0;
      bytes_left  = 8'h00;
      running_xor = 8'h00;
      frame_len   = 8'h00;
      frame_words.delete();
    end else begin
      if (cfg_psel && cfg_penable && cfg_pready && cfg_paddr[1:0] == 2'b00 &&
          cfg_paddr[CFG_ADDR_W-1:2] == REG_SYNC_WORD) begin
        if (cfg_pwrite) begin
          sync_word = cfg_pwdata;
        end else if (cfg_prdata !== sync_word) begin
          report_mismatch("sync_word readback", cfg_prdata, sync_word);
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        if (deframe_byte(in_mon.rx_byte, predicted)) frame_words.push_back(predicted);
      end
      if (out_mon.valid && out_mon.ready) begin
        seen = {out_mon.data_byte, out_mon.is_end, out_mon.frame_ok, out_mon.frame_length};
        if (frame_words.size() == 0) begin
          report_mismatch("word with nothing expected", 32'(seen), 32'h0);
        end else begin
          want = frame_words.pop_front();
          if (seen.data_byte !== want.data_byte)
            report_mismatch("data_byte", 32'(seen.data_byte), 32'(want.data_byte));
          if (seen.is_end !== want.is_end)
            report_mismatch("is_end", 32'(seen.is_end), 32'(want.is_end));
          if (seen.frame_ok !== want.frame_ok)
            report_mismatch("frame_ok", 32'(seen.frame_ok), 32'(want.frame_ok));
          if (seen.frame_length !== want.frame_length)
            report_mismatch("frame_length", 32'(seen.frame_length),
                            32'(want.frame_length));
        end
      end
    end
    pending <= frame_words.size();
  end

endmodule

>>> tb/tb_sync_length_xor_deframer.sv
// ----------------------------------------------------------------------------
// tb_sync_length_xor_deframer
// Feeds the deframer a directed opening (sync restarts, empty frames, good
// and bad checksums) and then random frame streams under several sync words,
// with noise, cut-off sync words and random pacing on both channels. The
// checker beside the block predicts and compares; this module gives the
// verdict.
// ----------------------------------------------------------------------------
module tb_sync_length_xor_deframer;
  import sld_pkg::*;

  localparam int unsigned CYCLE_LIMIT     = 400000;
  localparam int unsigned SETTLE_CYCLES   = 16;
  localparam int unsigned ITEMS_PER_PHASE = 125;
  localparam int unsigned PHASES          = 6;
  localparam int unsigned OPENING_LEN     = 23;

  localparam logic [CFG_ADDR_W-1:0] ADDR_SYNC_WORD = {REG_SYNC_WORD, 2'b00};
  localparam logic [CFG_ADDR_W-1:0] ADDR_PAST_LAST = {1'b1, 2'b00};

  // noise, sync restart on a repeated first byte, empty frame with good and
  // bad checksum, two-byte frame at the byte extremes
  localparam logic [OPENING_LEN*8-1:0] OPENING = {
    8'h00, 8'hFF, "SSYNC", 8'h00, 8'h00, "SYNC", 8'h00, 8'h5A,
    "SYNC", 8'h02, 8'hFF, 8'h00, 8'hFF
  };

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                  cfg_psel;
  logic                  cfg_penable;
  logic                  cfg_pwrite;
  logic [CFG_ADDR_W-1:0] cfg_paddr;
  logic [31:0]           cfg_pwdata;
  logic [31:0]           cfg_prdata;
  logic                  cfg_pready;

  logic        sink_ready = 1'b0;
  int unsigned sink_hold = 0;
  bit          out_burst = 1'b0;
  bit          in_burst = 1'b0;
  int unsigned cycle_count = 0;
  int unsigned sent_items = 0;
  int unsigned checker_fails;
  int unsigned pending_words;
  logic [31:0] sync_now = SYNC_WORD_RESET;

  sld_in_if  in_ch ();
  sld_out_if out_ch ();

  assign out_ch.ready = sink_ready;

  always #10 clk = ~clk;

  sync_length_xor_deframer u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_chan     (in_ch),
    .out_chan    (out_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  sld_frame_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_mon      (in_ch),
    .out_mon     (out_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .fail_count  (checker_fails),
    .pending     (pending_words)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Hold ready low for a drawn number of cycles after each result word, or not at all in burst mode.
  always @(posedge clk) begin : sink_pacing
    int unsigned draw;
    if ($urandom_range(0, 63) == 0) out_burst <= !out_burst;
    if (!rst_n) begin
      sink_ready <= 1'b0;
      sink_hold  <= 0;
    end else if (out_ch.valid && sink_ready) begin
      draw = out_burst ? 0 : $urandom_range(0, 7);
      sink_ready <= (draw == 0);
      sink_hold  <= (draw == 0) ? 0 : draw - 1;
    end else if (sink_hold != 0) begin
      sink_hold <= sink_hold - 1;
    end else begin
      sink_ready <= 1'b1;
    end
  end

  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    gap = in_burst ? 0 : $urandom_range(0, 7);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.rx_byte <= b;
    do @(posedge clk); while (!in_ch.ready);
    sent_items++;
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_words != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_access(input logic write, input logic [CFG_ADDR_W-1:0] addr,
                            input logic [31:0] data);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= write;
    cfg_paddr   <= addr;
    cfg_pwdata  <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
  endtask

  task automatic send_frame();
    int unsigned roll;
    int unsigned cut;
    int unsigned len;
    logic [7:0]  check;
    logic [7:0]  b;
    in_burst = ($urandom_range(0, 3) == 0);
    roll = $urandom_range(0, 99);
    if (roll < 10) begin
      repeat ($urandom_range(1, 4)) send_byte(8'($urandom));
    end else if (roll < 16) begin
      send_byte(sync_now[31:24]);
    end else if (roll < 24) begin
      cut = $urandom_range(1, 3);
      for (int k = 0; k < cut; k++) send_byte(sync_now[31 - 8 * k -: 8]);
      send_byte(8'($urandom));
      return;
    end
    for (int k = 0; k < 4; k++) send_byte(sync_now[31 - 8 * k -: 8]);
    roll = $urandom_range(0, 99);
    if (roll < 4) len = 255;
    else if (roll < 14) len = $urandom_range(0, 255);
    else len = $urandom_range(0, 8);
    send_byte(8'(len));
    check = 8'h00;
    repeat (len) begin
      b = 8'($urandom);
      check ^= b;
      send_byte(b);
    end
    send_byte(($urandom_range(0, 3) != 0) ? check : 8'($urandom));
  endtask

  initial begin : stimulus
    logic [31:0] word;
    in_ch.valid   <= 1'b0;
    in_ch.rx_byte <= 8'h00;
    cfg_psel      <= 1'b0;
    cfg_penable   <= 1'b0;
    cfg_pwrite    <= 1'b0;
    cfg_paddr     <= '0;
    cfg_pwdata    <= 32'h0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < OPENING_LEN; i++) begin
      in_burst = (i % 8 < 4);
      send_byte(OPENING[8 * (OPENING_LEN - 1 - i) +: 8]);
    end

    for (int p = 0; p < PHASES; p++) begin
      drain_results();
      case (p)
        0: word = 32'h0000_0000;
        1: word = 32'hFFFF_FFFF;
        2: word = 32'h7E7E_7E81;
        3, 4: word = $urandom;
        default: word = SYNC_WORD_RESET;
      endcase
      if (p == 0) cfg_access(1'b1, ADDR_PAST_LAST, $urandom);
      cfg_access(1'b1, ADDR_SYNC_WORD, word);
      cfg_access(1'b0, ADDR_SYNC_WORD, 32'h0);
      cfg_psel    <= 1'b0;
      cfg_penable <= 1'b0;
      sync_now = word;
      while (sent_items < ITEMS_PER_PHASE * (p + 1)) send_frame();
    end

    drain_results();
    if (checker_fails == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
